[rtl/core/strict_priority_multi_fifo_unit_macros.svh]
// Assertion macros used by the checker file of the multi-level queue
`ifndef STRICT_PRIORITY_MULTI_FIFO_UNIT_MACROS_SVH
`define STRICT_PRIORITY_MULTI_FIFO_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define SPMF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define SPMF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/spmf_pkg.sv]
// Types, constants and helpers of the strict priority multi-level queue
`timescale 1ns / 1ps

package spmf_pkg;

   // queue geometry
   localparam int LEVELS    = 4;
   localparam int SLOTS     = 16;
   localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int LVL_CNT_W = $clog2(LEVELS + 1);
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int ADDR_W    = LVL_W + SLOT_W;
   localparam int RAM_DEPTH = 1 << ADDR_W;

   // command codes
   localparam logic [1:0] CMD_ENQ  = 2'd0;
   localparam logic [1:0] CMD_DEQ  = 2'd1;
   localparam logic [1:0] CMD_SRCH = 2'd2;

   // status codes
   localparam logic [2:0] ST_ENQ      = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_DEQ      = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_FOUND    = 3'd4;
   localparam logic [2:0] ST_NOTFOUND = 3'd5;
   localparam logic [2:0] ST_BADCMD   = 3'd7;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  level;
      logic [31:0] entry_id;
      logic [31:0] name_key;
      logic [7:0]  entry_age;
      logic [63:0] entry_payload;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  out_level;
      logic [31:0] out_id;
      logic [31:0] out_name_key;
      logic [7:0]  out_age;
      logic [63:0] out_payload;
   } rsp_word_type;

   // one stored entry
   typedef struct packed {
      logic [31:0] id;
      logic [31:0] key;
      logic [7:0]  age;
      logic [63:0] payload;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // pointer table update, one level at a time
   typedef struct packed {
      logic             push;
      logic             pop;
      logic [LVL_W-1:0] sel;
   } lvl_op_type;

   // pointers of the selected level
   typedef struct packed {
      logic [SLOT_W-1:0] head;
      logic [SLOT_W-1:0] tail;
      logic [CNT_W-1:0]  count;
   } lvl_view_type;

   // entry memory access
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
   } ram_cmd_type;

   // circular slot advance
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      r = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
      return r;
   endfunction

endpackage

[rtl/core/spmf_ram.sv]
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps

module spmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/spmf_lvl_table.sv]
// Head, tail and fill count of every level
`timescale 1ns / 1ps

module spmf_lvl_table import spmf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  lvl_op_type         lvl_op,
   output lvl_view_type       lvl_view,
   output logic [LEVELS-1:0]  nonempty
);

   logic [SLOT_W-1:0] head_ff  [LEVELS];
   logic [SLOT_W-1:0] tail_ff  [LEVELS];
   logic [CNT_W-1:0]  count_ff [LEVELS];

   // pointer update on the selected level
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         if (lvl_op.push) begin
            tail_ff[lvl_op.sel]  <= next_slot(tail_ff[lvl_op.sel]);
            count_ff[lvl_op.sel] <= count_ff[lvl_op.sel] + 1'b1;
         end
         if (lvl_op.pop) begin
            head_ff[lvl_op.sel]  <= next_slot(head_ff[lvl_op.sel]);
            count_ff[lvl_op.sel] <= count_ff[lvl_op.sel] - 1'b1;
         end
      end
   end

   // view of the selected level
   always_comb begin
      lvl_view.head  = head_ff[lvl_op.sel];
      lvl_view.tail  = tail_ff[lvl_op.sel];
      lvl_view.count = count_ff[lvl_op.sel];
   end

   // occupancy flags for the dequeue priority pick
   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         nonempty[i] = (count_ff[i] != '0);
      end
   end

endmodule

[rtl/core/spmf_seq.sv]
// Command sequencer: enqueue, dequeue and the entry-by-entry search walk
`timescale 1ns / 1ps

module spmf_seq import spmf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_word_type      req_word,
   output lvl_op_type        lvl_op,
   input  lvl_view_type      lvl_view,
   input  logic [LEVELS-1:0] nonempty,
   output ram_cmd_type       ram_cmd,
   output entry_type         ram_wr_data,
   input  entry_type         ram_rd_data,
   input  logic              out_free,
   output logic              res_valid,
   output rsp_word_type      res_word
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EXEC     = 3'd1;
   localparam logic [2:0] S_DEQ_RD   = 3'd2;
   localparam logic [2:0] S_SRCH_LVL = 3'd3;
   localparam logic [2:0] S_SRCH_RD  = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   logic [2:0]           state_ff, state_in;
   req_word_type         req_ff, req_in;
   logic [LVL_CNT_W-1:0] lv_ff, lv_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0]     seen_ff, seen_in;
   logic                 pend_ff, pend_in;
   logic [LVL_W-1:0]     pend_lvl_ff, pend_lvl_in;
   rsp_word_type         res_ff, res_in;

   logic [LVL_W-1:0] deq_lvl;
   logic             deq_any;
   logic             lvl_bad;
   logic             key_hit;

   // lowest-numbered non-empty level
   always_comb begin
      deq_lvl = '0;
      deq_any = 1'b0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (nonempty[i]) begin
            deq_lvl = LVL_W'(i);
            deq_any = 1'b1;
         end
      end
   end

   assign lvl_bad = (32'(req_ff.level) >= 32'(LEVELS));
   // single compare unit: one stored entry against the search key per cycle
   assign key_hit = (ram_rd_data.id == req_ff.entry_id) &&
                    (ram_rd_data.key == req_ff.name_key);

   assign ram_wr_data.id      = req_ff.entry_id;
   assign ram_wr_data.key     = req_ff.name_key;
   assign ram_wr_data.age     = req_ff.entry_age;
   assign ram_wr_data.payload = req_ff.entry_payload;

   // next-state logic
   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      lv_in       = lv_ff;
      slot_in     = slot_ff;
      seen_in     = seen_ff;
      pend_in     = pend_ff;
      pend_lvl_in = pend_lvl_ff;
      res_in      = res_ff;
      lvl_op.push = 1'b0;
      lvl_op.pop  = 1'b0;
      lvl_op.sel  = lv_ff[LVL_W-1:0];
      ram_cmd.wr_en = 1'b0;
      ram_cmd.rd_en = 1'b0;
      ram_cmd.addr  = {lv_ff[LVL_W-1:0], slot_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_word;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_in = '0;
            unique case (req_ff.cmd)
               CMD_ENQ: begin
                  lvl_op.sel = LVL_W'(req_ff.level);
                  if (lvl_bad || lvl_view.count == CNT_W'(SLOTS)) begin
                     res_in.status = ST_FULL;
                  end else begin
                     ram_cmd.wr_en = 1'b1;
                     ram_cmd.addr  = {LVL_W'(req_ff.level), lvl_view.tail};
                     lvl_op.push   = 1'b1;
                     res_in.status = ST_ENQ;
                  end
                  state_in = S_DONE;
               end
               CMD_DEQ: begin
                  lvl_op.sel = deq_lvl;
                  if (deq_any) begin
                     ram_cmd.rd_en    = 1'b1;
                     ram_cmd.addr     = {deq_lvl, lvl_view.head};
                     lvl_op.pop       = 1'b1;
                     res_in.status    = ST_DEQ;
                     res_in.out_level = 2'(deq_lvl);
                     state_in         = S_DEQ_RD;
                  end else begin
                     res_in.status = ST_EMPTY;
                     state_in      = S_DONE;
                  end
               end
               CMD_SRCH: begin
                  lv_in    = '0;
                  pend_in  = 1'b0;
                  state_in = S_SRCH_LVL;
               end
               default: begin
                  res_in.status = ST_BADCMD;
                  state_in      = S_DONE;
               end
            endcase
         end

         // entry read back in the state after the pop, from the registered RAM read
         S_DEQ_RD: begin
            res_in.out_id       = ram_rd_data.id;
            res_in.out_name_key = ram_rd_data.key;
            res_in.out_age      = ram_rd_data.age;
            res_in.out_payload  = ram_rd_data.payload;
            state_in            = S_DONE;
         end

         // open the next level, or finish when all are walked
         S_SRCH_LVL: begin
            if (lv_ff == LVL_CNT_W'(LEVELS)) begin
               res_in.status = ST_NOTFOUND;
               state_in      = S_DONE;
            end else begin
               slot_in  = lvl_view.head;
               seen_in  = '0;
               state_in = S_SRCH_RD;
            end
         end

         // read one entry a cycle, compare the one read in the cycle before
         S_SRCH_RD: begin
            if (pend_ff && key_hit) begin
               res_in.status    = ST_FOUND;
               res_in.out_level = 2'(pend_lvl_ff);
               state_in         = S_DONE;
            end else if (seen_ff == lvl_view.count) begin
               pend_in  = 1'b0;
               lv_in    = lv_ff + 1'b1;
               state_in = S_SRCH_LVL;
            end else begin
               ram_cmd.rd_en = 1'b1;
               slot_in       = next_slot(slot_ff);
               seen_in       = seen_ff + 1'b1;
               pend_in       = 1'b1;
               pend_lvl_in   = lv_ff[LVL_W-1:0];
            end
         end

         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      lv_ff       <= lv_in;
      slot_ff     <= slot_in;
      seen_ff     <= seen_in;
      pend_lvl_ff <= pend_lvl_in;
      res_ff      <= res_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_word  = res_ff;

endmodule

[rtl/core/strict_priority_multi_fifo_unit.sv]
// Strict priority multi-level queue: LEVELS circular queues of SLOTS entries
// in one entry RAM. One command word is taken at a time. Enqueue, an
// unknown command and a failed dequeue go from the execute state straight
// to the result, and a dequeue passes through a read-back state first. A
// search reads one stored entry per cycle through the single RAM read port
// while walking a level, and opens each level in a state of its own. A
// search that finds nothing walks every level and reads each entry held;
// one that hits stops after reading the match. The result sits in an
// output register, and the next word is taken while it waits to be
// collected. The entry RAM needs no clearing after reset; of the storage,
// only the pointer table is reset.
`timescale 1ns / 1ps

module strict_priority_multi_fifo_unit import spmf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   lvl_op_type        lvl_op;
   lvl_view_type      lvl_view;
   logic [LEVELS-1:0] nonempty;
   ram_cmd_type       ram_cmd;
   entry_type         ram_wr_data;
   entry_type         ram_rd_data;
   logic [ENTRY_W-1:0] ram_rd_bits;
   logic              out_free;
   logic              res_valid;
   rsp_word_type      res_word;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   spmf_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .lvl_op      (lvl_op),
      .lvl_view    (lvl_view),
      .nonempty    (nonempty),
      .ram_cmd     (ram_cmd),
      .ram_wr_data (ram_wr_data),
      .ram_rd_data (ram_rd_data),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res_word    (res_word)
   );

   spmf_lvl_table u_lvl_table (
      .clock    (clock),
      .reset    (reset),
      .lvl_op   (lvl_op),
      .lvl_view (lvl_view),
      .nonempty (nonempty)
   );

   spmf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RAM_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = entry_type'(ram_rd_bits);

   // output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[rtl/core/spmf_checker.sv]
// Port-level checks of the multi-level queue, bound to the top level
`timescale 1ns / 1ps
`include "strict_priority_multi_fifo_unit_macros.svh"

module spmf_checker import spmf_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // a held result word stays put until taken
   `SPMF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "result word changed while stalled")

   // one command at a time: the cycle after a word is taken the input stalls
   `SPMF_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "second word taken while busy")

   // only a dequeue carries entry fields
   `SPMF_ASSERT_NOW(a_entry_zero, rsp_valid && rsp_word.status != ST_DEQ, rsp_word.out_id == '0 && rsp_word.out_name_key == '0 && rsp_word.out_age == '0 && rsp_word.out_payload == '0, "entry fields set on non-dequeue result")

   // only a dequeue or a hit carries a level
   `SPMF_ASSERT_NOW(a_level_zero, rsp_valid && rsp_word.status != ST_DEQ && rsp_word.status != ST_FOUND, rsp_word.out_level == '0, "level set on result without one")

endmodule

bind strict_priority_multi_fifo_unit spmf_checker u_spmf_checker (.*);
